// File: hdl/lcdnw_pkg.sv
// lcdnw_pkg: shared types, codes and pin word helpers for the character lcd nibble writer
// no dependencies; used by lcdnw_front, lcdnw_back and char_lcd_nibble_writer
`default_nettype none

package lcdnw_pkg;

    // request kinds as they arrive on the input
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_CURSOR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FUNCTION = 2'd0;
    localparam logic [1:0] CFG_DISPLAY  = 2'd1;
    localparam logic [1:0] CFG_ENTRY    = 2'd2;

    localparam logic [7:0] FUNCTION_RESET = 8'h28;
    localparam logic [7:0] DISPLAY_RESET  = 8'h0c;
    localparam logic [7:0] ENTRY_RESET    = 8'h06;

    // cursor row base addresses, also the home command
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hc0;

    // fixed pin words of the reset nibble sequence
    localparam logic [7:0] PIN_ALL_OUT  = 8'h00;
    localparam logic [7:0] PIN_ALL_HIGH = 8'hff;
    localparam logic [7:0] PIN_RST_EN   = 8'h61;
    localparam logic [7:0] PIN_RST      = 8'h60;
    localparam logic [7:0] PIN_4BIT_EN  = 8'h21;
    localparam logic [7:0] PIN_4BIT     = 8'h20;

    localparam logic [4:0] PAUSE_NONE   = 5'd0;
    localparam logic [4:0] PAUSE_STEP   = 5'd1;
    localparam logic [4:0] PAUSE_END    = 5'd2;
    localparam logic [4:0] PAUSE_LONG   = 5'd20;
    localparam logic [4:0] PAUSE_RST1   = 5'd15;
    localparam logic [4:0] PAUSE_RST2   = 5'd5;
    localparam logic [4:0] PAUSE_4BIT   = 5'd6;

    // sequencer step counts
    localparam int          STEP_W     = 5;
    localparam logic [4:0]  INIT_FIXED = 5'd10;
    localparam logic [4:0]  INIT_LAST  = 5'd25;
    localparam logic [1:0]  CMD_LAST   = 2'd3;
    localparam logic [4:0]  DATA_LAST  = 5'd5;

    // request queue between front and back
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INIT,
        OP_CMD,
        OP_DATA
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] cmd;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_link;

    typedef struct packed {
        logic       dir;
        logic [7:0] pin;
        logic [4:0] pause;
        logic       last;
    } t_word;

    // nibble reversed onto bits 6..3
    function automatic logic [7:0] nib_word(input logic [3:0] n);
        return {1'b0, n[0], n[1], n[2], n[3], 3'b000};
    endfunction

    // one of the four words of a command byte
    function automatic t_word cmd_word(input logic [7:0] c, input logic [1:0] sub);
        t_word      w;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = nib_word(c[7:4]);
        lo = nib_word(c[3:0]);
        w  = '0;
        case (sub)
            2'd0: begin
                w.pin   = hi | 8'h01;
                w.pause = PAUSE_STEP;
            end
            2'd1: begin
                w.pin   = hi;
                w.pause = PAUSE_STEP;
            end
            2'd2: begin
                w.pin   = lo | 8'h01;
                w.pause = PAUSE_STEP;
            end
            default: begin
                w.pin   = lo;
                w.pause = PAUSE_END;
            end
        endcase
        return w;
    endfunction

    // one of the six words of a data byte, register select set
    function automatic t_word data_word(input logic [7:0] c, input logic [2:0] s);
        t_word      w;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = nib_word(c[7:4]) | 8'h02;
        lo = nib_word(c[3:0]) | 8'h02;
        w  = '0;
        case (s)
            3'd0: begin
                w.pin   = hi | 8'h01;
                w.pause = PAUSE_NONE;
            end
            3'd1: begin
                w.pin   = hi | 8'h01;
                w.pause = PAUSE_STEP;
            end
            3'd2: begin
                w.pin   = hi;
                w.pause = PAUSE_STEP;
            end
            3'd3: begin
                w.pin   = lo | 8'h01;
                w.pause = PAUSE_NONE;
            end
            3'd4: begin
                w.pin   = lo | 8'h01;
                w.pause = PAUSE_STEP;
            end
            default: begin
                w.pin   = lo;
                w.pause = PAUSE_END;
            end
        endcase
        return w;
    endfunction

    // fixed head of the init sequence: direction write and reset nibbles
    function automatic t_word init_word(input logic [3:0] s);
        t_word w;
        w = '0;
        case (s)
            4'd0: begin
                w.dir = 1'b1;
                w.pin = PIN_ALL_OUT;
            end
            4'd1: begin
                w.pin   = PIN_ALL_HIGH;
                w.pause = PAUSE_LONG;
            end
            4'd2, 4'd4, 4'd6: w.pin = PIN_RST_EN;
            4'd3: begin
                w.pin   = PIN_RST;
                w.pause = PAUSE_RST1;
            end
            4'd5, 4'd7: begin
                w.pin   = PIN_RST;
                w.pause = PAUSE_RST2;
            end
            4'd8: w.pin = PIN_4BIT_EN;
            default: begin
                w.pin   = PIN_4BIT;
                w.pause = PAUSE_4BIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/char_lcd_nibble_writer.sv
// char_lcd_nibble_writer: top level of the 4-bit character lcd pin word sequencer
// depends on lcdnw_pkg, lcdnw_front and lcdnw_back
`default_nettype none

// Each request becomes a run of pin words, one word a cycle while results are
// being popped: a command or cursor move is 4 words, a data byte 6 and init
// 26. The back sequencer emits the words of the request at the head of a
// two-deep request queue; the front keeps taking requests until the queue holds
// two. The oldest word waits in a result register, and the next word is loaded
// in the same cycle that it is popped.
// Configuration writes take effect at once and should be made while idle.
module char_lcd_nibble_writer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_value,
    input  wire logic       i_row,
    input  wire logic [5:0] i_col,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_to_direction,
    output logic [7:0]      o_pin_word,
    output logic [4:0]      o_pause_units,
    output logic            o_last
);

    lcdnw_pkg::t_job_link link;
    lcdnw_pkg::t_word     word;
    logic                 deq;

    // request intake and queue
    lcdnw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_kind  (i_kind),
        .i_value (i_value),
        .i_row   (i_row),
        .i_col   (i_col),
        .o_link  (link),
        .i_deq   (deq)
    );

    // word sequencer and result register
    lcdnw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_link      (link),
        .o_deq       (deq),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (word)
    );

    assign o_to_direction = word.dir;
    assign o_pin_word     = word.pin;
    assign o_pause_units  = word.pause;
    assign o_last         = word.last;

endmodule

`default_nettype wire

// File: hdl/lcdnw_front.sv
// lcdnw_front: takes requests, turns each into an operation and byte, holds them in a short queue
// depends on lcdnw_pkg
`default_nettype none

module lcdnw_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [1:0]           i_kind,
    input  wire logic [7:0]           i_value,
    input  wire logic                 i_row,
    input  wire logic [5:0]           i_col,
    output lcdnw_pkg::t_job_link      o_link,
    input  wire logic                 i_deq
);

    lcdnw_pkg::t_job                       n_job;
    lcdnw_pkg::t_job                       r_q [lcdnw_pkg::JOBQ_DEPTH];
    logic [lcdnw_pkg::JOBQ_AW-1:0]         r_wr_ptr;
    logic [lcdnw_pkg::JOBQ_AW-1:0]         r_rd_ptr;
    logic [lcdnw_pkg::JOBQ_CW-1:0]         r_count;
    logic                                  enq;

    // classify the incoming beat
    always_comb begin
        n_job = '0;
        case (i_kind)
            lcdnw_pkg::KIND_CMD: begin
                n_job.op  = lcdnw_pkg::OP_CMD;
                n_job.cmd = i_value;
            end
            lcdnw_pkg::KIND_DATA: begin
                n_job.op  = lcdnw_pkg::OP_DATA;
                n_job.cmd = i_value;
            end
            lcdnw_pkg::KIND_CURSOR: begin
                n_job.op  = lcdnw_pkg::OP_CMD;
                n_job.cmd = (i_row ? lcdnw_pkg::ROW1_BASE : lcdnw_pkg::ROW0_BASE)
                            + {2'b00, i_col};
            end
            default: begin
                n_job.op  = lcdnw_pkg::OP_INIT;
                n_job.cmd = i_value;
            end
        endcase
    end

    assign o_full = (r_count == lcdnw_pkg::JOBQ_CW'(lcdnw_pkg::JOBQ_DEPTH));
    assign enq    = i_push && !o_full;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= n_job;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (enq && !i_deq) begin
                r_count <= r_count + 1'b1;
            end else if (i_deq && !enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_link.valid = (r_count != '0);
    assign o_link.job   = r_q[r_rd_ptr];

    // queue checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lcdnw_pkg::JOBQ_CW'(lcdnw_pkg::JOBQ_DEPTH))
        else $error("request queue count out of range");

    a_no_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_deq |-> (r_count != '0))
        else $error("request dequeued from empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

// File: hdl/lcdnw_back.sv
// lcdnw_back: emits the pin words of the queue head request, one word a cycle unless a held
// word is unpopped; depends on lcdnw_pkg; holds the configuration and result registers
`default_nettype none

module lcdnw_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    input  wire lcdnw_pkg::t_job_link i_link,
    output logic                      o_deq,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output lcdnw_pkg::t_word          o_word
);

    logic [7:0]                      r_function;
    logic [7:0]                      r_display;
    logic [7:0]                      r_entry;
    logic [lcdnw_pkg::STEP_W-1:0]    r_step;
    logic [lcdnw_pkg::STEP_W-1:0]    init_off;
    logic [7:0]                      init_cmd;
    lcdnw_pkg::t_word                n_word;
    lcdnw_pkg::t_word                r_word;
    logic                            r_valid;
    logic                            advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function <= lcdnw_pkg::FUNCTION_RESET;
            r_display  <= lcdnw_pkg::DISPLAY_RESET;
            r_entry    <= lcdnw_pkg::ENTRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdnw_pkg::CFG_FUNCTION: r_function <= i_cfg_data;
                lcdnw_pkg::CFG_DISPLAY:  r_display  <= i_cfg_data;
                lcdnw_pkg::CFG_ENTRY:    r_entry    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pick the set-up command for the tail of init
    assign init_off = r_step - lcdnw_pkg::INIT_FIXED;

    always_comb begin
        case (init_off[3:2])
            2'd0:    init_cmd = r_function;
            2'd1:    init_cmd = r_display;
            2'd2:    init_cmd = r_entry;
            default: init_cmd = lcdnw_pkg::ROW0_BASE;
        endcase
    end

    // word for the current step
    always_comb begin
        n_word = '0;
        case (i_link.job.op)
            lcdnw_pkg::OP_INIT: begin
                if (r_step < lcdnw_pkg::INIT_FIXED) begin
                    n_word = lcdnw_pkg::init_word(r_step[3:0]);
                end else begin
                    n_word = lcdnw_pkg::cmd_word(init_cmd, init_off[1:0]);
                end
                n_word.last = (r_step == lcdnw_pkg::INIT_LAST);
            end
            lcdnw_pkg::OP_CMD: begin
                n_word      = lcdnw_pkg::cmd_word(i_link.job.cmd, r_step[1:0]);
                n_word.last = (r_step[1:0] == lcdnw_pkg::CMD_LAST);
            end
            lcdnw_pkg::OP_DATA: begin
                n_word      = lcdnw_pkg::data_word(i_link.job.cmd, r_step[2:0]);
                n_word.last = (r_step == lcdnw_pkg::DATA_LAST);
            end
            default: begin
                n_word.last = 1'b1;
            end
        endcase
    end

    assign advance = i_link.valid && (!r_valid || i_pop);
    assign o_deq   = advance && n_word.last;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (advance) begin
            r_step <= n_word.last ? '0 : r_step + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word <= n_word;
        end
    end

    assign o_empty = !r_valid;
    assign o_word  = r_word;

    // sequencer checks
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= lcdnw_pkg::INIT_LAST)
        else $error("sequencer step out of range");

    a_step_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> i_link.valid)
        else $error("request left the queue in mid sequence");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |=> (r_step == '0))
        else $error("step counter not cleared after final word");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_valid)
        else $error("generated word not held for output");

endmodule

`default_nettype wire

// File: verif/char_lcd_nibble_writer_tb.sv
// char_lcd_nibble_writer_tb: self-checking testbench for the 4-bit character lcd pin word writer
// depends on lcdnw_pkg and char_lcd_nibble_writer; drives requests, pops pin words and checks
// every beat against a predicted pin word sequence
`default_nettype none

module char_lcd_nibble_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcdnw_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_IDLE      = 12;
    localparam int PHASE_ITEMS   = 75;
    localparam int NUM_PHASES    = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_AT_BEAT  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int NUM_DIRECTED  = 20;

    localparam logic [7:0] PIN_ENABLE = 8'h01;
    localparam logic [7:0] PIN_RS     = 8'h02;

    // one pin register write as seen on the result side
    typedef struct packed {
        logic       dir;
        logic [7:0] pin;
        logic [4:0] pause;
        logic       last;
    } pin_beat_t;

    // one directed request, with the final pin word typed in where obvious
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
        logic       typed;
        logic [7:0] last_pin;
    } lcd_request_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       push        = 1'b0;
    logic       full;
    logic [1:0] i_kind      = 2'd0;
    logic [7:0] i_value     = 8'd0;
    logic       i_row       = 1'b0;
    logic [5:0] i_col       = 6'd0;
    logic       empty;
    logic       pop         = 1'b0;
    logic       o_to_direction;
    logic [7:0] o_pin_word;
    logic [4:0] o_pause_units;
    logic       o_last;

    // shadow of the set-up commands sent during init
    logic [7:0] function_cmd = FUNCTION_RESET;
    logic [7:0] display_cmd  = DISPLAY_RESET;
    logic [7:0] entry_cmd    = ENTRY_RESET;

    pin_beat_t pending_pin_words [$];
    int        mismatch_count = 0;
    int        beat_count     = 0;
    int        idle_cycles    = 0;
    logic      sender_no_idle = 1'b0;

    lcd_request_t directed_rows [NUM_DIRECTED] = '{
        '{KIND_INIT,   8'h00, 1'b0, 6'd0,  1'b1, 8'h00},
        '{KIND_CMD,    8'h00, 1'b0, 6'd0,  1'b1, 8'h00},
        '{KIND_CMD,    8'hff, 1'b0, 6'd0,  1'b1, 8'h78},
        '{KIND_DATA,   8'h00, 1'b0, 6'd0,  1'b1, 8'h02},
        '{KIND_DATA,   8'hff, 1'b0, 6'd0,  1'b1, 8'h7a},
        '{KIND_CURSOR, 8'h00, 1'b0, 6'd0,  1'b1, 8'h00},
        '{KIND_CURSOR, 8'h00, 1'b1, 6'd39, 1'b1, 8'h70},
        '{KIND_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, 8'h78},
        '{KIND_CURSOR, 8'h00, 1'b0, 6'd40, 1'b0, 8'h00},
        '{KIND_CURSOR, 8'hff, 1'b0, 6'd63, 1'b0, 8'h00},
        '{KIND_CMD,    8'h5a, 1'b1, 6'd63, 1'b0, 8'h00},
        '{KIND_DATA,   8'ha5, 1'b1, 6'd42, 1'b0, 8'h00},
        '{KIND_DATA,   8'h3c, 1'b0, 6'd0,  1'b0, 8'h00},
        '{KIND_CMD,    8'h01, 1'b0, 6'd0,  1'b0, 8'h00},
        '{KIND_INIT,   8'hff, 1'b1, 6'd63, 1'b0, 8'h00},
        '{KIND_DATA,   8'h41, 1'b0, 6'd0,  1'b0, 8'h00},
        '{KIND_CMD,    8'h80, 1'b0, 6'd0,  1'b0, 8'h00},
        '{KIND_CURSOR, 8'h55, 1'b1, 6'd0,  1'b0, 8'h00},
        '{KIND_DATA,   8'h96, 1'b1, 6'd1,  1'b0, 8'h00},
        '{KIND_INIT,   8'h00, 1'b0, 6'd0,  1'b0, 8'h00}
    };

    char_lcd_nibble_writer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_row          (i_row),
        .i_col          (i_col),
        .empty          (empty),
        .pop            (pop),
        .o_to_direction (o_to_direction),
        .o_pin_word     (o_pin_word),
        .o_pause_units  (o_pause_units),
        .o_last         (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // nibble laid onto bits 6..3 with D4 on bit 6
    function automatic logic [7:0] nibble_pins(input logic [3:0] nib);
        logic [7:0] pins;
        pins = 8'h00;
        for (int i = 0; i < 4; i++) begin
            pins[6 - i] = nib[i];
        end
        return pins;
    endfunction

    task automatic queue_pin_word(input logic dir, input logic [7:0] pin,
                                  input logic [4:0] pause);
        pin_beat_t b;
        b.dir   = dir;
        b.pin   = pin;
        b.pause = pause;
        b.last  = 1'b0;
        pending_pin_words.push_back(b);
    endtask

    // instruction byte: two nibbles, each strobed then released
    task automatic predict_command(input logic [7:0] cmd);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = nibble_pins(cmd[7:4]);
        lo = nibble_pins(cmd[3:0]);
        queue_pin_word(1'b0, hi | PIN_ENABLE, 5'd1);
        queue_pin_word(1'b0, hi, 5'd1);
        queue_pin_word(1'b0, lo | PIN_ENABLE, 5'd1);
        queue_pin_word(1'b0, lo, 5'd2);
    endtask

    // character byte: register select set, enable-high word doubled per nibble
    task automatic predict_data(input logic [7:0] dat);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = nibble_pins(dat[7:4]) | PIN_RS;
        lo = nibble_pins(dat[3:0]) | PIN_RS;
        queue_pin_word(1'b0, hi | PIN_ENABLE, 5'd0);
        queue_pin_word(1'b0, hi | PIN_ENABLE, 5'd1);
        queue_pin_word(1'b0, hi, 5'd1);
        queue_pin_word(1'b0, lo | PIN_ENABLE, 5'd0);
        queue_pin_word(1'b0, lo | PIN_ENABLE, 5'd1);
        queue_pin_word(1'b0, lo, 5'd2);
    endtask

    // full pin word sequence for one accepted request
    task automatic predict_request(input lcd_request_t req);
        pin_beat_t  tail;
        logic [7:0] addr;
        case (req.kind)
            KIND_INIT: begin
                queue_pin_word(1'b1, 8'h00, 5'd0);
                queue_pin_word(1'b0, 8'hff, 5'd20);
                queue_pin_word(1'b0, 8'h61, 5'd0);
                queue_pin_word(1'b0, 8'h60, 5'd15);
                queue_pin_word(1'b0, 8'h61, 5'd0);
                queue_pin_word(1'b0, 8'h60, 5'd5);
                queue_pin_word(1'b0, 8'h61, 5'd0);
                queue_pin_word(1'b0, 8'h60, 5'd5);
                queue_pin_word(1'b0, 8'h21, 5'd0);
                queue_pin_word(1'b0, 8'h20, 5'd6);
                predict_command(function_cmd);
                predict_command(display_cmd);
                predict_command(entry_cmd);
                predict_command(ROW0_BASE);
            end
            KIND_CMD: predict_command(req.value);
            KIND_DATA: predict_data(req.value);
            default: begin
                // column is added to the row base even past the visible range
                addr = (req.row ? ROW1_BASE : ROW0_BASE) + {2'b00, req.col};
                predict_command(addr);
            end
        endcase
        tail = pending_pin_words[pending_pin_words.size() - 1];
        tail.last = 1'b1;
        if (req.typed) begin
            tail.pin = req.last_pin;
        end
        pending_pin_words[pending_pin_words.size() - 1] = tail;
    endtask

    // offer one request after a random or zero gap and wait until it is taken
    task automatic send_request(input lcd_request_t req);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_kind  <= req.kind;
        i_value <= req.value;
        i_row   <= req.row;
        i_col   <= req.col;
        do @(posedge i_clk); while (full);
        predict_request(req);
    endtask

    // stop offering and wait until every predicted word has been popped
    task automatic drain_pin_words();
        push <= 1'b0;
        while (pending_pin_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FUNCTION: function_cmd = data;
            CFG_DISPLAY:  display_cmd  = data;
            default:      entry_cmd    = data;
        endcase
    endtask

    task automatic apply_setup(input logic [7:0] fn, input logic [7:0] disp,
                               input logic [7:0] entry);
        drain_pin_words();
        write_setting(CFG_FUNCTION, fn);
        write_setting(CFG_DISPLAY, disp);
        write_setting(CFG_ENTRY, entry);
    endtask

    function automatic lcd_request_t random_request();
        lcd_request_t req;
        int           pick;
        pick      = $urandom_range(0, 99);
        req.kind  = (pick < 8)  ? KIND_INIT :
                    (pick < 38) ? KIND_CMD :
                    (pick < 78) ? KIND_DATA : KIND_CURSOR;
        req.value = 8'($urandom);
        req.row   = 1'($urandom);
        // mostly visible columns, now and then past the end of a line
        req.col   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63)) :
                                                  6'($urandom_range(0, 39));
        req.typed    = 1'b0;
        req.last_pin = 8'h00;
        return req;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // stimulus: reset, directed rows, then random phases over several set-ups
    initial begin
        lcd_request_t req;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_request(directed_rows[i]);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_setup(8'h00, 8'h00, 8'h00);
                1: apply_setup(8'hff, 8'hff, 8'hff);
                2: apply_setup(8'($urandom), 8'($urandom), 8'($urandom));
                default: apply_setup(FUNCTION_RESET, DISPLAY_RESET, ENTRY_RESET);
            endcase
            sender_no_idle = (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one mid-phase pause until the writer has run dry
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    drain_pin_words();
                end
                req = random_request();
                send_request(req);
            end
        end

        drain_pin_words();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("char_lcd_nibble_writer_tb: clean");
        end else begin
            $display("char_lcd_nibble_writer_tb: errors");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, recurring stretches with no stalls
    initial begin
        pin_beat_t want;
        int        stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = (beat_count % 400 < 80) ? 0 : $urandom_range(0, MAX_IDLE);
            if (beat_count == HOLD_AT_BEAT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            beat_count++;
            if (pending_pin_words.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual pin %0h",
                         $time, o_pin_word);
                mismatch_count++;
            end else begin
                want = pending_pin_words.pop_front();
                report_field("to_direction", 8'(want.dir), 8'(o_to_direction));
                report_field("pin_word", want.pin, o_pin_word);
                report_field("pause_units", 8'(want.pause), 8'(o_pause_units));
                report_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    // watchdog on cycles in which neither side moves a beat
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("char_lcd_nibble_writer_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
